@@ rtl/core/checked_integer_power_top_assert.svh @@
// Assertion macros for the checked integer power block.
// Used by the top level only; the clock and reset names are those of its ports.
`ifndef CHECKED_INTEGER_POWER_TOP_ASSERT_SVH
`define CHECKED_INTEGER_POWER_TOP_ASSERT_SVH

// Holds at every clock edge outside reset.
`define CIP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The antecedent in one cycle implies the consequent in the same cycle.
`define CIP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent in one cycle implies the consequent in the next cycle.
`define CIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cip_pkg.sv @@
// Shared types and constants of the checked integer power block.
// Depends on nothing; every other file of the block but the assertion header uses it.
package cip_pkg;

    localparam int DATA_W     = 64;
    localparam int EXP_W      = 64;
    localparam int STATUS_W   = 2;
    localparam int WIDTH_DEF  = 64;
    localparam int MUL_DIGITS = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NEG_EXP   = 2'd1,
        ST_ZERO_ZERO = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SQR  = 5'b01000,
        S_DONE = 5'b10000
    } t_ctl_state;

    // Status of the sequencer as seen by the top level.
    typedef struct packed {
        logic idle;
        logic done;
        logic over;
        logic neg;
    } t_ctl_res;

endpackage

@@ rtl/core/cip_if.sv @@
// Valid/ready channel interfaces for the operands and the result.
// Depends on cip_pkg for the payload widths.
interface cip_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [cip_pkg::DATA_W-1:0]  base_value;
    logic signed [cip_pkg::EXP_W-1:0]   exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface cip_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cip_pkg::DATA_W-1:0]  power_value;
    logic        [cip_pkg::STATUS_W-1:0] status;

    modport source (output valid, output power_value, output status, input ready);
    modport sink   (input valid, input power_value, input status, output ready);
endinterface

@@ rtl/core/checked_integer_power_top.sv @@
// Top level of the checked integer power block: operand checks, sequencer and result register.
// Depends on cip_pkg, cip_if, cip_ctrl and checked_integer_power_top_assert.svh.
//
// The block raises a signed base to a signed exponent and returns the exact power with a
// status code: ok, negative exponent, zero to zero, or overflow (the value is then zero).
// Only the low WIDTH bits of the base are used, and the power is sign-extended from WIDTH
// bits; the most negative WIDTH-bit value is a legal result. Items are handled one at a
// time. A negative exponent or zero to zero gives its result in the cycle after the input
// transfer. Otherwise the work is square-and-multiply on one shared digit-serial
// multiplier, which needs four passes for each product; an item forms at most 2n - 1
// products, where n is the bit length of the exponent, and overflow ends the loop
// early. Input ready stays low while an item is in work or while an earlier result waits
// in the output register and is not being taken.

`include "checked_integer_power_top_assert.svh"

module checked_integer_power_top #(
    parameter int WIDTH = cip_pkg::WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cip_in_if.sink    i_in,
    cip_out_if.source o_out
);

    localparam int DW = cip_pkg::DATA_W;

    logic                    r_out_valid, n_out_valid;
    logic signed [DW-1:0]    r_out_val, n_out_val;
    cip_pkg::t_status        r_out_status, n_out_status;

    logic                    w_out_free;
    logic                    w_accept;
    logic [WIDTH-1:0]        w_b;
    logic                    w_neg_exp;
    logic                    w_zero_zero;
    logic [WIDTH-1:0]        w_mag;
    logic                    w_rneg;
    logic                    w_start;
    cip_pkg::t_ctl_res       w_res;
    logic [WIDTH-1:0]        w_acc;
    logic [WIDTH-1:0]        w_val;

    // The output register is free when empty or when its result is taken in this cycle.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = w_res.idle && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    // Operand classification. The negative exponent check comes before the zero check.
    assign w_b         = i_in.base_value[WIDTH-1:0];
    assign w_neg_exp   = i_in.exponent[cip_pkg::EXP_W-1];
    assign w_zero_zero = (w_b == '0) && (i_in.exponent == '0);
    // The magnitude of the most negative base is 2^(WIDTH-1), still exact as unsigned.
    assign w_mag       = w_b[WIDTH-1] ? (~w_b + WIDTH'(1)) : w_b;
    assign w_rneg      = w_b[WIDTH-1] && i_in.exponent[0];
    assign w_start     = w_accept && !w_neg_exp && !w_zero_zero;

    cip_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_mag   (w_mag),
        .i_exp   (i_in.exponent[cip_pkg::EXP_W-2:0]),
        .i_neg   (w_rneg),
        .i_take  (w_out_free),
        .o_res   (w_res),
        .o_acc   (w_acc)
    );

    assign w_val = w_res.neg ? (~w_acc + WIDTH'(1)) : w_acc;

    // Results come either straight from the operand checks or from the finished sequencer;
    // the two never compete because input ready requires an idle sequencer.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_val    = r_out_val;
        n_out_status = r_out_status;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept && w_neg_exp) begin
            n_out_valid  = 1'b1;
            n_out_val    = '0;
            n_out_status = cip_pkg::ST_NEG_EXP;
        end else if (w_accept && w_zero_zero) begin
            n_out_valid  = 1'b1;
            n_out_val    = '0;
            n_out_status = cip_pkg::ST_ZERO_ZERO;
        end else if (w_res.done && w_out_free) begin
            n_out_valid = 1'b1;
            if (w_res.over) begin
                n_out_val    = '0;
                n_out_status = cip_pkg::ST_OVERFLOW;
            end else begin
                n_out_val    = DW'($signed(w_val));
                n_out_status = cip_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val    <= n_out_val;
        r_out_status <= n_out_status;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.power_value = r_out_val;
    assign o_out.status      = r_out_status;

    // An input transfer never lands on a result that is still waiting.
    `CIP_ASSERT_SAME(a_no_clobber, w_accept, w_out_free, "input taken while result pending")

    // A negative exponent is answered in the next cycle with its own status.
    `CIP_ASSERT_NEXT(a_neg_exp_fast, w_accept && w_neg_exp,
        o_out.valid && (o_out.status == cip_pkg::ST_NEG_EXP), "negative exponent not reported")

    // A started power computation keeps the input closed in the following cycle.
    `CIP_ASSERT_NEXT(a_busy_closed, w_start, !i_in.ready, "input open while sequencer busy")

    // Every status other than ok carries a zero power.
    `CIP_ASSERT_ALWAYS(a_err_zero,
        !o_out.valid || (o_out.status == cip_pkg::ST_OK) || (o_out.power_value == '0),
        "error result with nonzero power")

endmodule

@@ rtl/core/cip_mul.sv @@
// Digit-serial unsigned multiplier shared by every step of the power loop.
// Depends on cip_pkg for the digit count.
module cip_mul #(
    parameter int WIDTH = cip_pkg::WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic               o_done,
    output logic [2*WIDTH-1:0] o_prod
);

    localparam int K  = (WIDTH + cip_pkg::MUL_DIGITS - 1) / cip_pkg::MUL_DIGITS;
    localparam int BW = cip_pkg::MUL_DIGITS * K;
    localparam int PW = WIDTH + BW;
    localparam int CW = $clog2(cip_pkg::MUL_DIGITS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [WIDTH-1:0] r_a;
    logic [BW-1:0]    r_b;
    logic [PW-1:0]    r_p;

    logic [WIDTH+K-1:0] w_pp;
    logic [WIDTH+K-1:0] w_sum;

    // One digit of b per cycle; the partial sum shifts right by a digit each pass.
    assign w_pp  = (WIDTH+K)'(r_a) * (WIDTH+K)'(r_b[K-1:0]);
    assign w_sum = w_pp + (WIDTH+K)'(r_p[PW-1 -: WIDTH]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(cip_pkg::MUL_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= BW'(i_b);
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[BW-1:K]};
            r_b <= r_b >> K;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p[2*WIDTH-1:0];

endmodule

@@ rtl/core/cip_ctrl.sv @@
// Square-and-multiply sequencer with overflow tracking.
// Depends on cip_pkg and instantiates cip_mul.
module cip_ctrl #(
    parameter int WIDTH = cip_pkg::WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [WIDTH-1:0]          i_mag,
    input  logic [cip_pkg::EXP_W-2:0] i_exp,
    input  logic                      i_neg,
    input  logic                      i_take,
    output cip_pkg::t_ctl_res         o_res,
    output logic [WIDTH-1:0]          o_acc
);

    localparam int EW = cip_pkg::EXP_W - 1;

    cip_pkg::t_ctl_state r_state, n_state;
    logic [EW-1:0]    r_e, n_e;
    logic [WIDTH-1:0] r_term, n_term;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic             r_term_over, n_term_over;
    logic             r_over, n_over;
    logic             r_neg, n_neg;

    logic               w_mul_start;
    logic [WIDTH-1:0]   w_ma;
    logic [WIDTH-1:0]   w_mb;
    logic               w_mul_done;
    logic [2*WIDTH-1:0] w_prod;
    logic [WIDTH-1:0]   w_half;
    logic [WIDTH-1:0]   w_limit;
    logic               w_big;
    logic               w_sq_go;

    cip_mul #(.WIDTH(WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // A negative result may reach one step further than a positive one.
    assign w_half  = WIDTH'(1) << (WIDTH - 1);
    assign w_limit = r_neg ? w_half : w_half - WIDTH'(1);
    assign w_big   = w_prod > (2*WIDTH)'(w_limit);
    // The square is needed only if another exponent bit follows and the term is in range.
    assign w_sq_go = (r_e[EW-1:1] != '0) && !r_term_over;

    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_term      = r_term;
        n_acc       = r_acc;
        n_term_over = r_term_over;
        n_over      = r_over;
        n_neg       = r_neg;
        w_mul_start = 1'b0;
        w_ma        = r_term;
        w_mb        = r_term;
        case (r_state)
            cip_pkg::S_IDLE: begin
                if (i_start) begin
                    n_term      = i_mag;
                    n_acc       = WIDTH'(1);
                    n_e         = i_exp;
                    n_term_over = 1'b0;
                    n_over      = 1'b0;
                    n_neg       = i_neg;
                    n_state     = cip_pkg::S_CHK;
                end
            end
            cip_pkg::S_CHK: begin
                if (r_e == '0) begin
                    n_state = cip_pkg::S_DONE;
                end else if (r_e[0]) begin
                    if (r_term_over) begin
                        n_over  = 1'b1;
                        n_state = cip_pkg::S_DONE;
                    end else begin
                        w_mul_start = 1'b1;
                        w_ma        = r_acc;
                        n_state     = cip_pkg::S_MUL;
                    end
                end else begin
                    n_e = r_e >> 1;
                    if (w_sq_go) begin
                        w_mul_start = 1'b1;
                        n_state     = cip_pkg::S_SQR;
                    end
                end
            end
            cip_pkg::S_MUL: begin
                if (w_mul_done) begin
                    if (w_big) begin
                        n_over  = 1'b1;
                        n_state = cip_pkg::S_DONE;
                    end else begin
                        n_acc = w_prod[WIDTH-1:0];
                        n_e   = r_e >> 1;
                        if (w_sq_go) begin
                            w_mul_start = 1'b1;
                            n_state     = cip_pkg::S_SQR;
                        end else begin
                            n_state = cip_pkg::S_CHK;
                        end
                    end
                end
            end
            cip_pkg::S_SQR: begin
                if (w_mul_done) begin
                    if (w_big) begin
                        n_term_over = 1'b1;
                    end else begin
                        n_term = w_prod[WIDTH-1:0];
                    end
                    n_state = cip_pkg::S_CHK;
                end
            end
            cip_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = cip_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cip_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cip_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e         <= n_e;
        r_term      <= n_term;
        r_acc       <= n_acc;
        r_term_over <= n_term_over;
        r_over      <= n_over;
        r_neg       <= n_neg;
    end

    assign o_res.idle = (r_state == cip_pkg::S_IDLE);
    assign o_res.done = (r_state == cip_pkg::S_DONE);
    assign o_res.over = r_over;
    assign o_res.neg  = r_neg;
    assign o_acc      = r_acc;

endmodule

@@ test/power_result_checker.sv @@
// Watches the operand and result channels of the checked integer power block and
// compares each result transfer with an independently computed power and status.
// Depends on cip_pkg and the channel interfaces in cip_if.
module power_result_checker #(
    parameter int WIDTH = cip_pkg::WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cip_in_if    i_operand,
    cip_out_if   i_result,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0]      base_value;
        logic [63:0]      exponent;
        logic [63:0]      power_value;
        cip_pkg::t_status status;
    } t_power_case;

    t_power_case awaited_powers[$];
    int          mismatch_count = 0;

    // Square-and-multiply on exact 128-bit products; a product beyond the signed range
    // of the result marks overflow, and a squared term that left the range only
    // matters once an exponent bit pulls it into the accumulator.
    function automatic t_power_case raise_checked(logic [63:0] base_raw, logic [63:0] exp_raw);
        t_power_case res;
        logic [63:0]  half;
        logic [63:0]  mask;
        logic [63:0]  b;
        logic [63:0]  e;
        logic [63:0]  mag;
        logic [63:0]  limit;
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [127:0] prod;
        logic         neg_result;
        logic         term_wrapped;
        logic         over;

        half = 64'd1 << (WIDTH - 1);
        mask = half | (half - 64'd1);
        res.base_value  = base_raw;
        res.exponent    = exp_raw;
        res.power_value = '0;
        res.status      = cip_pkg::ST_OK;
        e = exp_raw;
        if (e[63]) begin
            res.status = cip_pkg::ST_NEG_EXP;
            return res;
        end
        b = base_raw & mask;
        if ((b & half) != 0)
            b = b | ~mask;
        if (b == 0 && e == 0) begin
            res.status = cip_pkg::ST_ZERO_ZERO;
            return res;
        end
        mag          = ((b & half) != 0) ? 64'd0 - b : b;
        neg_result   = ((b & half) != 0) && e[0];
        limit        = neg_result ? half : half - 64'd1;
        acc          = 64'd1;
        term         = mag;
        term_wrapped = 1'b0;
        over         = 1'b0;
        while (e != 0 && !over) begin
            if (e[0]) begin
                prod = {64'd0, acc} * {64'd0, term};
                if (term_wrapped || prod > {64'd0, limit})
                    over = 1'b1;
                else
                    acc = prod[63:0];
            end
            e = e >> 1;
            if (!over && e != 0 && !term_wrapped) begin
                prod = {64'd0, term} * {64'd0, term};
                if (prod > {64'd0, limit})
                    term_wrapped = 1'b1;
                else
                    term = prod[63:0];
            end
        end
        if (over) begin
            res.status = cip_pkg::ST_OVERFLOW;
        end else begin
            res.power_value = neg_result ? 64'd0 - acc : acc;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_power_case want;
        if (i_rst_n) begin
            // Results are checked before operands are taken, so a result cannot match
            // an operand transfer of the same edge.
            if (i_result.valid && i_result.ready) begin
                if (awaited_powers.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: power %h status %0d",
                                            i_result.power_value, i_result.status));
                end else begin
                    want = awaited_powers.pop_front();
                    if (i_result.power_value !== want.power_value)
                        flag_mismatch($sformatf(
                            "power mismatch for %h ** %h: expected %h got %h",
                            want.base_value, want.exponent, want.power_value,
                            i_result.power_value));
                    if (i_result.status !== want.status)
                        flag_mismatch($sformatf(
                            "status mismatch for %h ** %h: expected %s got %0d",
                            want.base_value, want.exponent, want.status.name(),
                            i_result.status));
                end
            end
            if (i_operand.valid && i_operand.ready)
                awaited_powers.push_back(raise_checked(i_operand.base_value,
                                                       i_operand.exponent));
        end
        o_pending    <= awaited_powers.size();
        o_fail_count <= mismatch_count;
    end

endmodule

@@ test/checked_integer_power_top_tb.sv @@
// Top of the checked integer power testbench: clock, reset, operand stimulus and
// result back-pressure, with the checker beside the block and the final verdict.
// Depends on cip_pkg, cip_if, the block's RTL and power_result_checker.
module checked_integer_power_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF         = 6;
    localparam int          RESET_CYCLES     = 8;
    localparam int          RANDOM_ITEMS     = 1900;
    localparam int          LONG_HOLD_CYCLES = 3000;
    localparam int          DRAIN_CYCLES     = 20;
    // The limit is several times the slowest legal run of about 1900 items, plus receiver
    // stalls and sender gaps.
    localparam int          CYCLE_LIMIT      = 6_000_000;
    localparam int          DIRECTED_ITEMS   = 25;
    localparam logic [63:0] MOST_POS         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEG         = 64'h8000_0000_0000_0000;

    // Directed operand pairs: zero to zero, negative exponents, zero exponents, the
    // range extremes of the base, results that land exactly on the most negative
    // value, the edges of overflow for squares and odd powers, and bases of zero and
    // one with the largest exponent, where the loop runs over every exponent bit.
    localparam logic [63:0] DIRECTED_BASE [DIRECTED_ITEMS] = '{
        64'd0, 64'd0, 64'd5, -64'sd7, MOST_NEG,
        MOST_POS, MOST_NEG, -64'sd2, 64'd2, 64'd2,
        -64'sd2, 64'd0, 64'd1, -64'sd1, -64'sd1,
        64'd3037000499, 64'd3037000500, -64'sd3037000499, 64'd1 << 32, 64'd3,
        64'd3, MOST_POS, -64'sd3, 64'd7, MOST_NEG
    };
    localparam logic [63:0] DIRECTED_EXP [DIRECTED_ITEMS] = '{
        64'd0, -64'sd1, 64'd0, 64'd0, 64'd1,
        64'd1, 64'd2, 64'd63, 64'd63, 64'd62,
        64'd62, MOST_POS, MOST_POS, MOST_POS, MOST_POS - 64'd1,
        64'd2, 64'd2, 64'd2, 64'd1, 64'd39,
        64'd40, MOST_NEG, 64'd39, 64'd22, 64'd0
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic long_hold_req;
    logic long_hold_done  = 1'b0;
    int   hold_left       = 0;
    int   stall_mode      = 0;
    int   mode_age        = 0;
    int   cycle_count     = 0;
    int   fail_count;
    int   pending_results;

    cip_in_if  operand_ch ();
    cip_out_if result_ch ();

    checked_integer_power_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (operand_ch),
        .o_out   (result_ch)
    );

    power_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operand    (operand_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // The watchdog ends a run that hangs; a correct run never gets near the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result back-pressure. Every so often the receiver picks a new stall mode: always
    // ready, coin flip, mostly stalled, or a fixed duty cycle. Once the stimulus asks
    // for it, the receiver holds ready low for a long stretch, counted here, while the
    // sender keeps offering operands, so the block has to stall its input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            result_ch.ready <= 1'b0;
            hold_left       <= LONG_HOLD_CYCLES;
            long_hold_done  <= 1'b1;
        end else begin
            if (mode_age == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_age   <= $urandom_range(50, 300);
            end else begin
                mode_age <= mode_age - 1;
            end
            case (stall_mode)
                0: begin
                    result_ch.ready <= 1'b1;
                end
                1: begin
                    result_ch.ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    result_ch.ready <= ($urandom_range(0, 5) == 0);
                end
                default: begin
                    result_ch.ready <= (mode_age % 16) < 10;
                end
            endcase
        end
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Random operands, weighted toward cases near the overflow boundary: small bases
    // with moderate exponents, powers of two and bases of random bit length with
    // exponents around 63 divided by their size, full-width bases with tiny exponents,
    // bases of magnitude up to two with exponents of random length (up to the full
    // loop), negative exponents, and the zero cases.
    task automatic pick_operands(output logic [63:0] b, output logic [63:0] e);
        int kind;
        int k;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                b = 64'($urandom_range(0, 40));
                e = 64'($urandom_range(0, 80));
            end
            3, 4: begin
                k = $urandom_range(0, 63);
                b = 64'd1 << k;
                if (k == 0)
                    e = 64'($urandom_range(0, 200));
                else
                    e = 64'(63 / k - 1 + $urandom_range(0, 2));
            end
            5: begin
                k = $urandom_range(1, 63);
                b = random_word() >> (64 - k);
                e = 64'(63 / k - 1 + $urandom_range(0, 2));
            end
            6: begin
                b = random_word();
                e = 64'($urandom_range(0, 3));
            end
            7: begin
                b = 64'($urandom_range(0, 2));
                e = random_word() >> $urandom_range(1, 63);
            end
            8: begin
                b = $urandom_range(0, 3) == 0 ? 64'd0 : random_word();
                e = random_word() | MOST_NEG;
            end
            default: begin
                if ($urandom_range(0, 1)) begin
                    b = 64'd0;
                    e = 64'($urandom_range(0, 3));
                end else begin
                    b = random_word();
                    e = 64'd0;
                end
            end
        endcase
        if (kind <= 7 && kind != 6 && $urandom_range(0, 1))
            b = 64'd0 - b;
    endtask

    // Offers one operand pair and returns at the edge of its transfer, or after the gap
    // that follows if the transfer ends a burst. The sender works in bursts; valid drops
    // for a random gap, mostly short, now and then long enough to leave the block idle.
    task automatic offer_operands(input logic [63:0] b, input logic [63:0] e,
                                  inout int burst_left);
        int gap;
        operand_ch.valid      <= 1'b1;
        operand_ch.base_value <= b;
        operand_ch.exponent   <= e;
        do
            @(posedge i_clk);
        while (!operand_ch.ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150)
                                              : $urandom_range(1, 6);
            operand_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every awaited result has come back. The checker's
    // count is registered and so lags behind a transfer, hence the first edge.
    task automatic wait_for_results();
        operand_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [63:0] b;
        logic [63:0] e;
        int          burst_left;
        operand_ch.valid      <= 1'b0;
        operand_ch.base_value <= '0;
        operand_ch.exponent   <= '0;
        long_hold_req         <= 1'b0;
        i_rst_n               <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 12);
        for (int n = 0; n < DIRECTED_ITEMS; n++)
            offer_operands(DIRECTED_BASE[n], DIRECTED_EXP[n], burst_left);
        wait_for_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3)
                long_hold_req <= 1'b1;
            if (n == 2 * RANDOM_ITEMS / 3)
                wait_for_results();
            pick_operands(b, e);
            offer_operands(b, e, burst_left);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cip_pkg.sv
rtl/core/cip_if.sv
rtl/core/cip_mul.sv
rtl/core/cip_ctrl.sv
rtl/core/checked_integer_power_top.sv
test/power_result_checker.sv
test/checked_integer_power_top_tb.sv
